FILE: hw/rtl/bba_pkg.sv
package bba_pkg;

  // Field widths of the request and result channels
  localparam int CMD_W   = 2;
  localparam int START_W = 12;
  localparam int COUNT_W = 13;
  localparam int LIMIT_W = 13;
  localparam int INDEX_W = 12;

  // Bitmap geometry
  localparam int WORD_BITS      = 32;
  localparam int WORD_SHIFT     = 5;
  localparam int OFS_W          = WORD_SHIFT + 1;
  localparam int NUM_BLOCKS_DEF = 4096;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

  // Bit masks for the one-hot to position encoder
  localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_BITS-1:0] MASK_16  = 32'hFFFF_0000;
  localparam logic [WORD_BITS-1:0] MASK_8   = 32'hFF00_FF00;
  localparam logic [WORD_BITS-1:0] MASK_4   = 32'hF0F0_F0F0;
  localparam logic [WORD_BITS-1:0] MASK_2   = 32'hCCCC_CCCC;
  localparam logic [WORD_BITS-1:0] MASK_1   = 32'hAAAA_AAAA;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] block_count;
    logic [LIMIT_W-1:0] limit_block;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [INDEX_W-1:0] alloc_block;
  } res_t;

  // Keep only the lowest set bit
  function automatic logic [WORD_BITS-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    return v & (~v + 32'd1);
  endfunction

  // Position of the single set bit
  function automatic logic [WORD_SHIFT-1:0] onehot_pos(input logic [WORD_BITS-1:0] v);
    return {|(v & MASK_16), |(v & MASK_8), |(v & MASK_4), |(v & MASK_2), |(v & MASK_1)};
  endfunction

  // Ones at bit positions lo up to hi-1
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [OFS_W-1:0] lo,
                                                      input logic [OFS_W-1:0] hi);
    logic [WORD_BITS-1:0] m;
    for (int k = 0; k < WORD_BITS; k++) begin
      m[k] = (OFS_W'(k) >= lo) && (OFS_W'(k) < hi);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/bba_req_if.sv
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::CMD_W-1:0]   command;
  logic [bba_pkg::START_W-1:0] start_block;
  logic [bba_pkg::COUNT_W-1:0] block_count;
  logic [bba_pkg::LIMIT_W-1:0] limit_block;

  modport source (output valid, command, start_block, block_count, limit_block,
                  input ready);
  modport sink (input valid, command, start_block, block_count, limit_block,
                output ready);
endinterface

FILE: hw/rtl/bba_rsp_if.sv
interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [bba_pkg::INDEX_W-1:0] alloc_block;

  modport source (output valid, success, alloc_block, input ready);
  modport sink (input valid, success, alloc_block, output ready);
endinterface

FILE: hw/rtl/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bba_engine.sv
module bba_engine #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  localparam int WORDS = NUM_BLOCKS / bba_pkg::WORD_BITS,
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bba_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bba_pkg::res_t                 res,
  output logic                          mem_we,
  output logic [WA_W-1:0]               mem_waddr,
  output logic [bba_pkg::WORD_BITS-1:0] mem_wdata,
  output logic [WA_W-1:0]               mem_raddr,
  input  logic [bba_pkg::WORD_BITS-1:0] mem_rdata
);

  localparam int WS       = bba_pkg::WORD_SHIFT;
  localparam int OW       = bba_pkg::OFS_W;
  localparam int BLK_CLOG = $clog2(NUM_BLOCKS + 1);
  localparam int BW       = ((BLK_CLOG > bba_pkg::COUNT_W) ? BLK_CLOG : bba_pkg::COUNT_W) + 1;
  localparam int WW       = BW - WS;

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FIND  = 6'b000100,
    S_CHECK = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [BW-1:0] pos, pos_next;
  logic [BW-1:0] num, num_next;
  logic [BW-1:0] lim_end, lim_end_next;
  logic [BW-1:0] cand, cand_next;
  logic [BW-1:0] rng_first, rng_first_next;
  logic [BW-1:0] rng_last, rng_last_next;
  logic [WW-1:0] rw, rw_next;
  logic [WA_W-1:0] ssw, ssw_next;
  logic [WA_W-1:0] cw, cw_next;
  logic          have, have_next;
  logic          set_bits, set_bits_next;
  bba_pkg::res_t res_next;

  // Request decode
  logic [BW-1:0]   blk_first, blk_count, blk_limit, n_blk;
  logic [BW-1:0]   req_sum, req_last, req_end, ssw_blk;
  logic [WA_W-1:0] start_word;

  // Search datapath
  logic [WW-1:0]                 pos_w, pos_w_inc;
  logic [bba_pkg::WORD_BITS-1:0] find_v;
  logic                          find_full, find_over;
  logic [BW-1:0]                 find_idx, find_idx_p1;

  // Range walk datapath
  logic [BW-1:0]                 last_m1, win, win_sum;
  logic [WW-1:0]                 first_w, last_w, win_w, rw_inc, rd_word;
  logic [OW-1:0]                 seg_lo, seg_hi;
  logic                          seg_last;
  logic [bba_pkg::WORD_BITS-1:0] seg_mask, used;
  logic [WA_W-1:0]               win_ssw;

  assign blk_first  = BW'(req.start_block);
  assign blk_count  = BW'(req.block_count);
  assign blk_limit  = BW'(req.limit_block);
  assign n_blk      = BW'(NUM_BLOCKS);
  assign req_sum    = blk_first + blk_count;
  assign req_last   = (req_sum > n_blk) ? n_blk : req_sum;
  assign req_end    = (blk_limit > n_blk) ? n_blk : blk_limit;
  assign ssw_blk    = BW'({ssw, {WS{1'b0}}});
  assign start_word = (ssw_blk >= req_end) ? '0 : ssw;

  // Lowest free block at or above the scan point
  assign pos_w       = pos[BW-1:WS];
  assign pos_w_inc   = pos_w + WW'(1);
  assign find_v      = mem_rdata | bba_pkg::range_mask(OW'(0), OW'(pos[WS-1:0]));
  assign find_full   = (find_v == bba_pkg::ALL_ONES);
  assign find_idx    = {pos_w, bba_pkg::onehot_pos(bba_pkg::lowest_one(~find_v))};
  assign find_idx_p1 = find_idx + BW'(1);
  assign find_over   = (find_idx + num) > lim_end;

  // Bits of the current word that fall inside the range
  assign first_w  = rng_first[BW-1:WS];
  assign last_m1  = rng_last - BW'(1);
  assign last_w   = last_m1[BW-1:WS];
  assign seg_last = (rw == last_w);
  assign seg_lo   = (rw == first_w) ? OW'(rng_first[WS-1:0]) : '0;
  assign seg_hi   = seg_last ? (OW'(last_m1[WS-1:0]) + OW'(1)) : OW'(bba_pkg::WORD_BITS);
  assign seg_mask = bba_pkg::range_mask(seg_lo, seg_hi);
  assign used     = mem_rdata & seg_mask;
  assign rw_inc   = rw + WW'(1);

  // Run that was found: fresh from the search or held from the check
  assign win     = (state == S_FIND) ? find_idx : cand;
  assign win_sum = win + num;
  assign win_w   = win[BW-1:WS];
  assign win_ssw = (have && (cw != '0)) ? cw : win_w[WA_W-1:0];

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign mem_waddr = rw[WA_W-1:0];
  assign mem_raddr = rd_word[WA_W-1:0];

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    num_next       = num;
    lim_end_next   = lim_end;
    cand_next      = cand;
    rng_first_next = rng_first;
    rng_last_next  = rng_last;
    rw_next        = rw;
    ssw_next       = ssw;
    cw_next        = cw;
    have_next      = have;
    set_bits_next  = set_bits;
    res_next       = res;
    rd_word        = rw;
    mem_we         = 1'b0;
    mem_wdata      = set_bits ? (mem_rdata | seg_mask) : (mem_rdata & ~seg_mask);

    case (state)
      // Sweep zeros through the bitmap after reset
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (rw == WW'(WORDS - 1)) begin
          rw_next    = '0;
          state_next = S_IDLE;
        end else begin
          rw_next = rw_inc;
        end
      end

      // Take a request and issue the first read
      S_IDLE: begin
        if (req_valid) begin
          res_next = '0;
          case (req.command)
            bba_pkg::CMD_ALLOC: begin
              if (blk_count == '0) begin
                state_next = S_DONE;
              end else begin
                ssw_next     = start_word;
                pos_next     = BW'({start_word, {WS{1'b0}}});
                rd_word      = WW'(start_word);
                have_next    = 1'b0;
                cw_next      = '0;
                num_next     = blk_count;
                lim_end_next = req_end;
                state_next   = S_FIND;
              end
            end
            bba_pkg::CMD_FREE, bba_pkg::CMD_MARK: begin
              res_next.success = 1'b1;
              set_bits_next    = (req.command == bba_pkg::CMD_MARK);
              if (blk_first >= req_last) begin
                state_next = S_DONE;
              end else begin
                rng_first_next = blk_first;
                rng_last_next  = req_last;
                rw_next        = blk_first[BW-1:WS];
                rd_word        = blk_first[BW-1:WS];
                state_next     = S_WRITE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Find the next free block; advance a word when this one is full
      S_FIND: begin
        if (find_full) begin
          if (pos_w_inc == WW'(WORDS)) begin
            ssw_next   = (have && (cw != '0)) ? cw : '0;
            state_next = S_DONE;
          end else begin
            pos_next = {pos_w_inc, {WS{1'b0}}};
            rd_word  = pos_w_inc;
          end
        end else if (find_over) begin
          state_next = S_DONE;
        end else if (num == BW'(1)) begin
          ssw_next             = win_ssw;
          res_next.success     = 1'b1;
          res_next.alloc_block = win[bba_pkg::INDEX_W-1:0];
          rng_first_next       = win;
          rng_last_next        = win_sum;
          rw_next              = win_w;
          rd_word              = win_w;
          set_bits_next        = 1'b1;
          state_next           = S_WRITE;
        end else begin
          cand_next      = find_idx;
          rng_first_next = find_idx_p1;
          rng_last_next  = find_idx + num;
          rw_next        = find_idx_p1[BW-1:WS];
          rd_word        = find_idx_p1[BW-1:WS];
          state_next     = S_CHECK;
        end
      end

      // Check the rest of the run word by word; resume at the first used block
      S_CHECK: begin
        if (used != '0) begin
          if (!have) begin
            have_next = 1'b1;
            cw_next   = rw[WA_W-1:0];
          end
          pos_next   = {rw, bba_pkg::onehot_pos(bba_pkg::lowest_one(used))};
          rd_word    = rw;
          state_next = S_FIND;
        end else if (seg_last) begin
          ssw_next             = win_ssw;
          res_next.success     = 1'b1;
          res_next.alloc_block = win[bba_pkg::INDEX_W-1:0];
          rng_first_next       = win;
          rng_last_next        = win_sum;
          rw_next              = win_w;
          rd_word              = win_w;
          set_bits_next        = 1'b1;
          state_next           = S_WRITE;
        end else begin
          rw_next = rw_inc;
          rd_word = rw_inc;
        end
      end

      // Read, modify and write back one word per cycle
      S_WRITE: begin
        mem_we = 1'b1;
        if (seg_last) begin
          state_next = S_DONE;
        end else begin
          rw_next = rw_inc;
          rd_word = rw_inc;
        end
      end

      // Hold the result until the output register takes it
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      rw    <= '0;
      ssw   <= '0;
    end else begin
      state <= state_next;
      rw    <= rw_next;
      ssw   <= ssw_next;
    end
    pos       <= pos_next;
    num       <= num_next;
    lim_end   <= lim_end_next;
    cand      <= cand_next;
    rng_first <= rng_first_next;
    rng_last  <= rng_last_next;
    cw        <= cw_next;
    have      <= have_next;
    set_bits  <= set_bits_next;
    res       <= res_next;
  end

  // Reset always restarts the clearing sweep
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLR)
    else $error("clearing sweep not started after reset");

  // The scan point never leaves the bitmap
  a_find_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FIND |-> pos[BW-1:WS] < WW'(WORDS))
    else $error("scan point past the last word");

  // A run under check always ends at or below the limit
  a_check_in_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> ({1'b0, cand} + {1'b0, num}) <= {1'b0, lim_end})
    else $error("run under check passes the limit");

  // The check starts just after the candidate block
  a_check_follows_cand: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> rng_first == cand + BW'(1))
    else $error("check range detached from candidate");

  // Writes stay within the words of the range
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> (rw >= first_w) && (rw <= last_w))
    else $error("write outside the range");

endmodule

FILE: hw/rtl/bitmap_block_allocator.sv
// Bitmap block allocator: one used/free bit per block, kept in a RAM of 32-bit words.
// Request channel (req): command, start_block, block_count, limit_block. Command
// alloc looks first-fit for block_count free blocks from the rotating start word up
// to limit_block and marks them used; free clears and mark sets a block range.
// Result channel (rsp): success and alloc_block, one result per request, in order.
// Sequence: the request is taken, then the bitmap words touched are worked one by one
// (alloc: each word scanned for a free block, each word of a run checked, a word
// revisited after a conflict, then each word marked); the result is then held until it
// loads the output register. Free and mark write each word spanned.
// The single RAM port pair, one word read and one written per cycle, sets the rate;
// one request is worked on at a time.
// Reset: synchronous, active high. Afterwards a sweep writes zero to every word,
// NUM_BLOCKS/32 words (128 at the default), and req.ready stays low meanwhile.
// Stall: the result waits in the output register while rsp.ready is low; the next
// request is taken and worked on, and it holds its own result until that register
// frees up.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input logic       clk,
  input logic       rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);

  localparam int WORDS = NUM_BLOCKS / bba_pkg::WORD_BITS;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

  bba_pkg::req_t                 req_word;
  bba_pkg::res_t                 res;
  logic                          res_valid, res_ready;
  logic                          mem_we;
  logic [WA_W-1:0]               mem_waddr, mem_raddr;
  logic [bba_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;
  logic                          out_valid;
  bba_pkg::res_t                 out_res;

  assign req_word.command     = req.command;
  assign req_word.start_block = req.start_block;
  assign req_word.block_count = req.block_count;
  assign req_word.limit_block = req.limit_block;

  bba_engine #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req       (req_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bba_ram #(
    .WIDTH (bba_pkg::WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load when empty or being drained, drop when taken
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.success     = out_res.success;
  assign rsp.alloc_block = out_res.alloc_block;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NUM_BLK    = bba_pkg::NUM_BLOCKS_DEF;
  localparam int WORD_TOTAL = NUM_BLK / bba_pkg::WORD_BITS;
  localparam logic [bba_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator state
  logic [bba_pkg::WORD_BITS-1:0] shadow_bitmap [WORD_TOTAL];
  int unsigned                   shadow_start_word;

  // Runs handed out and not yet returned
  int unsigned live_base [$];
  int unsigned live_len [$];

  bba_pkg::res_t pending_outcomes [$];
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;

  // Index of the lowest clear bit of a word that is not all ones
  function automatic int unsigned first_clear(input logic [bba_pkg::WORD_BITS-1:0] v);
    for (int k = 0; k < bba_pkg::WORD_BITS; k++) begin
      if (!v[k]) return k;
    end
    return 0;
  endfunction

  // Set or clear a block range, clipped at the end of the bitmap
  function automatic void set_blocks(input int unsigned first, input int unsigned count,
                                     input bit used);
    int unsigned last;
    int unsigned b;
    last = first + count;
    if (last > NUM_BLK) last = NUM_BLK;
    for (b = first; b < last; b++) shadow_bitmap[b >> 5][b % 32] = used;
  endfunction

  // First-fit search from the start word up to the limit, no wrap
  function automatic bit find_and_claim(input int unsigned num, input int unsigned lim,
                                        output int unsigned where);
    int unsigned top;
    int unsigned w;
    int unsigned idx;
    int unsigned c;
    int unsigned j;
    int unsigned conflict_word;
    bit have;
    bit hit;
    logic [bba_pkg::WORD_BITS-1:0] v;
    where = 0;
    top = (lim > NUM_BLK) ? NUM_BLK : lim;
    if (num == 0) return 1'b0;
    if (shadow_start_word * bba_pkg::WORD_BITS >= top) shadow_start_word = 0;
    have = 1'b0;
    conflict_word = 0;
    w = shadow_start_word;
    while (w < WORD_TOTAL) begin
      v = shadow_bitmap[w];
      while (v != '1) begin
        idx = w * bba_pkg::WORD_BITS + first_clear(v);
        if (idx + num > top) return 1'b0;
        hit = 1'b0;
        for (j = 1; j < num && !hit; j++) begin
          c = idx + j;
          if (shadow_bitmap[c >> 5][c % 32]) begin
            // resume just past the used block
            w = c >> 5;
            v = shadow_bitmap[w] | ((32'd1 << (c % 32)) - 32'd1);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          shadow_start_word = (have && conflict_word > 0) ? conflict_word : w;
          set_blocks(idx, num, 1'b1);
          where = idx;
          return 1'b1;
        end
        if (!have) begin
          have = 1'b1;
          conflict_word = w;
        end
      end
      w++;
    end
    shadow_start_word = (have && conflict_word > 0) ? conflict_word : 0;
    return 1'b0;
  endfunction

  // Apply one request to the shadow state and give the result it must produce
  function automatic bba_pkg::res_t allocator_outcome(input bba_pkg::req_t r);
    bba_pkg::res_t o;
    int unsigned where;
    o.success = 1'b0;
    o.alloc_block = '0;
    case (r.command)
      bba_pkg::CMD_ALLOC: begin
        if (find_and_claim(32'(r.block_count), 32'(r.limit_block), where)) begin
          o.success = 1'b1;
          o.alloc_block = bba_pkg::INDEX_W'(where);
          live_base.push_back(where);
          live_len.push_back(32'(r.block_count));
        end
      end
      bba_pkg::CMD_FREE: begin
        set_blocks(32'(r.start_block), 32'(r.block_count), 1'b0);
        o.success = 1'b1;
      end
      bba_pkg::CMD_MARK: begin
        set_blocks(32'(r.start_block), 32'(r.block_count), 1'b1);
        o.success = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Drive one request, hold it until taken, then record its outcome
  task automatic send_request(input logic [bba_pkg::CMD_W-1:0] cmd,
                              input logic [bba_pkg::START_W-1:0] start,
                              input logic [bba_pkg::COUNT_W-1:0] count,
                              input logic [bba_pkg::LIMIT_W-1:0] lim);
    bba_pkg::req_t r;
    r.command = cmd;
    r.start_block = start;
    r.block_count = count;
    r.limit_block = lim;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= r.command;
    req_ch.start_block <= r.start_block;
    req_ch.block_count <= r.block_count;
    req_ch.limit_block <= r.limit_block;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_outcomes.push_back(allocator_outcome(r));
  endtask

  // Result checker
  always @(posedge clk) begin
    bba_pkg::res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with none expected: success=%0d alloc_block=%0d",
               rsp_ch.success, rsp_ch.alloc_block);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_ch.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, rsp_ch.success);
          error_count++;
        end
        if (rsp_ch.alloc_block !== want.alloc_block) begin
          $error("alloc_block: expected %0d, got %0d", want.alloc_block,
                 rsp_ch.alloc_block);
          error_count++;
        end
      end
    end
  end

  // Result-side backpressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Simple runs, a conflict, and early and full-scan failures
  task automatic test_alloc_paths();
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd1, 13'd4096);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd31, 13'd4096);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd2, 13'd4096);
    send_request(bba_pkg::CMD_MARK, 12'd100, 13'd1, 13'd0);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd70, 13'd4096);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd4096, 13'd4096);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd1, 13'd16);
    send_request(bba_pkg::CMD_FREE, 12'd0, 13'd4096, 13'd0);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd1, 13'd0);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd4096, 13'd4096);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd1, 13'd4096);
  endtask

  // Ranges past the end, zero counts, oversize limit, unused command
  task automatic test_corner_requests();
    send_request(bba_pkg::CMD_FREE, 12'd4000, 13'd200, 13'd0);
    send_request(bba_pkg::CMD_MARK, 12'd4090, 13'd10, 13'd0);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd6, 13'd8191);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd0, 13'd4096);
    send_request(bba_pkg::CMD_FREE, 12'd5, 13'd0, 13'd0);
    send_request(bba_pkg::CMD_MARK, 12'd5, 13'd0, 13'd0);
    send_request(CMD_UNUSED, 12'd4095, 13'd8191, 13'd8191);
    send_request(bba_pkg::CMD_FREE, 12'd4095, 13'd1, 13'd0);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd1, 13'd4096);
    send_request(bba_pkg::CMD_FREE, 12'd0, 13'd4096, 13'd0);
    send_request(bba_pkg::CMD_MARK, 12'd2730, 13'd1365, 13'd0);
    send_request(bba_pkg::CMD_FREE, 12'd1365, 13'd2730, 13'd0);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd5, 13'd2730);
    send_request(bba_pkg::CMD_ALLOC, 12'd0, 13'd3, 13'd1365);
  endtask

  // Mostly alloc/free cycles on live runs, with marks and stray frees as noise
  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    int sel;
    int k;
    int unsigned count;
    int unsigned lim;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (n) begin
      sel = $urandom_range(99);
      if (live_base.size() > 48 || (sel < 30 && live_base.size() > 0)) begin
        // return one live run
        k = $urandom_range(live_base.size() - 1);
        send_request(bba_pkg::CMD_FREE, bba_pkg::START_W'(live_base[k]),
                     bba_pkg::COUNT_W'(live_len[k]), bba_pkg::LIMIT_W'($urandom_range(8191)));
        live_base.delete(k);
        live_len.delete(k);
      end else if (sel < 38) begin
        send_request(bba_pkg::CMD_MARK, bba_pkg::START_W'($urandom_range(4095)),
                     bba_pkg::COUNT_W'($urandom_range(64, 1)),
                     bba_pkg::LIMIT_W'($urandom_range(8191)));
      end else if (sel < 44) begin
        send_request(bba_pkg::CMD_FREE, bba_pkg::START_W'($urandom_range(4095)),
                     bba_pkg::COUNT_W'($urandom_range(4096, 1)),
                     bba_pkg::LIMIT_W'($urandom_range(8191)));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) count = $urandom_range(32, 1);
        else if (sel < 92) count = $urandom_range(300, 33);
        else if (sel < 98) count = $urandom_range(1200, 301);
        else count = $urandom_range(4096, 1);
        lim = ($urandom_range(99) < 80) ? 4096 : $urandom_range(4096);
        send_request(bba_pkg::CMD_ALLOC, bba_pkg::START_W'($urandom_range(4095)),
                     bba_pkg::COUNT_W'(count), bba_pkg::LIMIT_W'(lim));
      end
    end
  endtask

  initial begin
    for (int w = 0; w < WORD_TOTAL; w++) shadow_bitmap[w] = '0;
    shadow_start_word = 0;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= bba_pkg::CMD_ALLOC;
    req_ch.start_block <= '0;
    req_ch.block_count <= '0;
    req_ch.limit_block <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_alloc_paths();
    test_corner_requests();
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 73, 0);
    test_random_traffic(450, 0, 73);
    test_random_traffic(450, 21, 21);

    // drain outstanding results, then let the block settle
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
